// ===== rtl/bifv_pkg.sv =====
`default_nettype none
package bifv_pkg;

  localparam int FIELD_W  = 48;
  localparam int HALF_W   = 16;
  localparam int CORNER_W = 17;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int CNT_W    = 3;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // one classified face query, as held in the queue
  typedef struct packed {
    axis_t             axis;
    logic              axis_neg;   // chosen axis coordinate is -half
    logic              reverse;    // emit corners 3,2,1,0
    logic [HALF_W-1:0] half_z;
    logic [HALF_W-1:0] half_y;
    logic [HALF_W-1:0] half_x;
  } face_t;

  typedef struct packed {
    logic  valid;
    face_t face;
  } face_push_t;

  // bit c set: coordinate c of that corner is negative (chosen axis excluded)
  function automatic logic [2:0] corner_neg(axis_t axis, logic [1:0] src);
    logic [2:0] m;
    m = 3'b000;
    unique case (axis)
      AXIS_X: begin
        unique case (src)
          2'd0: m = 3'b000;
          2'd1: m = 3'b010;
          2'd2: m = 3'b110;
          default: m = 3'b100;
        endcase
      end
      AXIS_Y: begin
        unique case (src)
          2'd0: m = 3'b000;
          2'd1: m = 3'b100;
          2'd2: m = 3'b101;
          default: m = 3'b001;
        endcase
      end
      AXIS_Z: begin
        unique case (src)
          2'd0: m = 3'b000;
          2'd1: m = 3'b001;
          2'd2: m = 3'b011;
          default: m = 3'b010;
        endcase
      end
      default: m = 3'b000;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bifv_ifs.sv =====
`default_nettype none
interface bifv_query_if;
  logic                         valid;
  logic                         ready;
  logic [bifv_pkg::FIELD_W-1:0] axis_x_packed;
  logic [bifv_pkg::FIELD_W-1:0] axis_y_packed;
  logic [bifv_pkg::FIELD_W-1:0] axis_z_packed;
  logic [bifv_pkg::FIELD_W-1:0] normal_packed;
  logic [bifv_pkg::FIELD_W-1:0] half_sizes_packed;
  logic                         back_side;

  modport source(output valid, axis_x_packed, axis_y_packed, axis_z_packed,
                 normal_packed, half_sizes_packed, back_side, input ready);
  modport sink(input valid, axis_x_packed, axis_y_packed, axis_z_packed,
               normal_packed, half_sizes_packed, back_side, output ready);
endinterface

interface bifv_corner_if;
  logic                                valid;
  logic                                ready;
  logic signed [bifv_pkg::CORNER_W-1:0] corner_x;
  logic signed [bifv_pkg::CORNER_W-1:0] corner_y;
  logic signed [bifv_pkg::CORNER_W-1:0] corner_z;
  logic [1:0]                          corner_slot;
  logic [1:0]                          face_axis;
  logic                                last_corner;

  modport source(output valid, corner_x, corner_y, corner_z, corner_slot,
                 face_axis, last_corner, input ready);
  modport sink(input valid, corner_x, corner_y, corner_z, corner_slot,
               face_axis, last_corner, output ready);
endinterface
`default_nettype wire

// ===== rtl/box_incident_face_vertices_top.sv =====
// Incident face selection for an oriented box.
// query channel (sink): three box axes and a contact normal, each three signed
// Q1.14 components packed x-low, half sizes packed x-low, and a back-face flag.
// corner channel (source): four transfers per query, the local corners of the
// chosen face, with slot number, chosen axis and a last-corner flag.
// The first corner passes the product stage, the dot product stage, the queue
// and the corner output register; the others follow one per cycle when the
// receiver takes them, from the single corner output register, which sets the
// query rate. Queries may arrive back to back;
// up to 4 are held between the dot product pipeline and the corner sequencer.
// Synchronous reset empties the pipeline and queue and drops any pending
// corner. When the receiver stalls, the corner register holds, the queue fills,
// and query ready drops once 4 queries are outstanding.
`default_nettype none
module box_incident_face_vertices_top #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  bifv_query_if.sink     query,
  bifv_corner_if.source  corner
);

  bifv_pkg::face_push_t push;   // front to queue
  bifv_pkg::face_push_t head;   // queue to back
  logic                 pop;

  // front: products, dot sums, axis choice; owns the credit count
  bifv_front #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .query (query),
    .pop   (pop),
    .push  (push)
  );

  bifv_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head)
  );

  // back: steps four corners out of the queue head
  bifv_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .corner (corner)
  );

endmodule
`default_nettype wire

// ===== rtl/bifv_front.sv =====
`default_nettype none
module bifv_front #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  bifv_query_if.sink            query,
  input  wire logic             pop,
  output bifv_pkg::face_push_t  push
);

  localparam int CB   = COMPONENT_BITS;
  localparam int PW   = 2 * CB;
  localparam int DW   = 2 * CB + 2;
  localparam int PADW = (3 * CB > bifv_pkg::FIELD_W) ? 3 * CB : bifv_pkg::FIELD_W;

  // credits: items accepted and not yet popped from the queue
  logic [bifv_pkg::CNT_W-1:0] count;
  logic                       take;

  assign query.ready = (count < bifv_pkg::CNT_W'(bifv_pkg::QDEPTH));
  assign take        = query.valid && query.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + bifv_pkg::CNT_W'(take) - bifv_pkg::CNT_W'(pop);
    end
  end

  // unpack; bits past the 48-bit field read as zero
  logic [PADW-1:0] ax_pad, ay_pad, az_pad, n_pad;
  assign ax_pad = PADW'(query.axis_x_packed);
  assign ay_pad = PADW'(query.axis_y_packed);
  assign az_pad = PADW'(query.axis_z_packed);
  assign n_pad  = PADW'(query.normal_packed);

  // stage 1: nine products
  logic                 v1;
  logic signed [PW-1:0] prod [3][3];
  logic [bifv_pkg::FIELD_W-1:0] half1;
  logic                 back1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int c = 0; c < 3; c++) begin
        prod[0][c] <= $signed(ax_pad[c*CB +: CB]) * $signed(n_pad[c*CB +: CB]);
        prod[1][c] <= $signed(ay_pad[c*CB +: CB]) * $signed(n_pad[c*CB +: CB]);
        prod[2][c] <= $signed(az_pad[c*CB +: CB]) * $signed(n_pad[c*CB +: CB]);
      end
      half1 <= query.half_sizes_packed;
      back1 <= query.back_side;
    end
  end

  // stage 2: three dot products
  logic                 v2;
  logic signed [DW-1:0] dot [3];
  logic [bifv_pkg::FIELD_W-1:0] half2;
  logic                 back2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      for (int a = 0; a < 3; a++) begin
        dot[a] <= DW'(prod[a][0]) + DW'(prod[a][1]) + DW'(prod[a][2]);
      end
      half2 <= half1;
      back2 <= back1;
    end
  end

  // classify: largest magnitude, earlier axis on a tie
  logic [DW-1:0]        mag [3];
  logic signed [DW-1:0] chosen;
  bifv_pkg::axis_t      axis;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = dot[a][DW-1] ? DW'(-dot[a]) : DW'(dot[a]);
    end
    chosen = dot[0];
    axis   = bifv_pkg::AXIS_X;
    if (mag[1] > mag[0]) begin
      chosen = dot[1];
      axis   = bifv_pkg::AXIS_Y;
    end
    if (mag[2] > ((mag[1] > mag[0]) ? mag[1] : mag[0])) begin
      chosen = dot[2];
      axis   = bifv_pkg::AXIS_Z;
    end
  end

  always_comb begin
    push.valid         = v2;
    push.face.axis     = axis;
    push.face.axis_neg = (chosen <= 0) ^ back2;
    push.face.reverse  = chosen[DW-1];
    push.face.half_x   = half2[0 +: bifv_pkg::HALF_W];
    push.face.half_y   = half2[bifv_pkg::HALF_W +: bifv_pkg::HALF_W];
    push.face.half_z   = half2[2*bifv_pkg::HALF_W +: bifv_pkg::HALF_W];
  end

endmodule
`default_nettype wire

// ===== rtl/bifv_queue.sv =====
`default_nettype none
module bifv_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bifv_pkg::face_push_t  push,
  input  wire logic                  pop,
  output bifv_pkg::face_push_t       head
);

  bifv_pkg::face_t               slots [bifv_pkg::QDEPTH];
  logic [bifv_pkg::QPTR_W-1:0]   wr_ptr;
  logic [bifv_pkg::QPTR_W-1:0]   rd_ptr;
  logic [bifv_pkg::CNT_W-1:0]    fill;

  // no overflow check: the front hands out only QDEPTH credits
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + bifv_pkg::CNT_W'(push.valid) - bifv_pkg::CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.face;
    end
  end

  assign head.valid = (fill != '0);
  assign head.face  = slots[rd_ptr];

endmodule
`default_nettype wire

// ===== rtl/bifv_back.sv =====
`default_nettype none
module bifv_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bifv_pkg::face_push_t  head,
  output logic                       pop,
  bifv_corner_if.source              corner
);

  logic [1:0] k;        // corner number within the current face
  logic       advance;
  logic       load;
  logic [1:0] src;
  logic [2:0] neg;
  logic [bifv_pkg::CORNER_W-1:0] val [3];
  logic [bifv_pkg::HALF_W-1:0]   half [3];

  assign advance = !corner.valid || corner.ready;
  assign load    = advance && head.valid;
  assign pop     = load && (k == 2'd3);

  always_comb begin
    half[0] = head.face.half_x;
    half[1] = head.face.half_y;
    half[2] = head.face.half_z;
    src     = head.face.reverse ? 2'(2'd3 - k) : k;
    neg     = bifv_pkg::corner_neg(head.face.axis, src);
    for (int c = 0; c < 3; c++) begin
      if (c == int'(head.face.axis)) begin
        neg[c] = head.face.axis_neg;
      end
      val[c] = neg[c] ? -{1'b0, half[c]} : {1'b0, half[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      corner.valid <= 1'b0;
      k            <= '0;
    end else if (load) begin
      corner.valid <= 1'b1;
      k            <= k + 1'b1;
    end else if (advance) begin
      corner.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      corner.corner_x    <= val[0];
      corner.corner_y    <= val[1];
      corner.corner_z    <= val[2];
      corner.corner_slot <= k;
      corner.face_axis   <= head.face.axis;
      corner.last_corner <= (k == 2'd3);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bifv_checker.sv =====
`default_nettype none
module bifv_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       corner_valid,
  input wire logic       corner_ready,
  input wire logic [1:0] corner_slot,
  input wire logic [1:0] face_axis,
  input wire logic       last_corner
);

  a_rst_clears: assert property (@(posedge clk) rst |=> !corner_valid)
    else $error("corner valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    corner_valid && !corner_ready |=> corner_valid)
    else $error("corner dropped while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    corner_valid |-> (last_corner == (corner_slot == 2'd3)))
    else $error("last flag and slot disagree");

  a_seq: assert property (@(posedge clk) disable iff (rst)
    (corner_valid && corner_ready && !last_corner) ##1 corner_valid |->
      (corner_slot == 2'($past(corner_slot) + 2'd1)) && (face_axis == $past(face_axis)))
    else $error("corner sequence broken within a face");

endmodule

bind box_incident_face_vertices_top bifv_checker u_bifv_checker (
  .clk          (clk),
  .rst          (rst),
  .corner_valid (corner.valid),
  .corner_ready (corner.ready),
  .corner_slot  (corner.corner_slot),
  .face_axis    (corner.face_axis),
  .last_corner  (corner.last_corner)
);
`default_nettype wire
